// ===== src/xed_pkg.sv =====
// Shared types, constants and character tables for the encoding declaration extractor.
package xed_pkg;

    localparam int NAME_MAX_DEF = 64;
    localparam int LEN_W        = 7;
    localparam int ADDR_W       = 6;
    localparam int DOC_W        = 5;
    localparam logic [DOC_W-1:0] MIN_DOC = 5'd20;
    localparam logic [3:0] OPENER_LEN  = 4'd5;
    localparam logic [3:0] KEYWORD_LEN = 4'd8;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_EQUALS = 8'h3d;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_doc;
    } xed_in_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       found;
        logic       run_last;
    } xed_out_t;

    typedef struct packed {
        logic             bank;
        logic             found;
        logic [LEN_W-1:0] len;
    } xed_cmd_t;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } xed_wr_t;

    function automatic logic [7:0] opener_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h3c;
            3'd1: c = 8'h3f;
            3'd2: c = 8'h78;
            3'd3: c = 8'h6d;
            3'd4: c = 8'h6c;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h65;
            3'd1: c = 8'h6e;
            3'd2: c = 8'h63;
            3'd3: c = 8'h6f;
            3'd4: c = 8'h64;
            3'd5: c = 8'h69;
            3'd6: c = 8'h6e;
            3'd7: c = 8'h67;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/xed_front.sv =====
// Front end: accepts document bytes, parses the declaration and writes name bytes.
module xed_front #(
    parameter int NAME_MAX = xed_pkg::NAME_MAX_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  xed_pkg::xed_in_t s_payload,
    input  logic             q_full,
    output logic             q_push,
    output xed_pkg::xed_cmd_t q_cmd,
    output xed_pkg::xed_wr_t wr
);
    import xed_pkg::*;

    typedef enum logic [6:0] {
        PH_PREFIX = 7'b0000001,
        PH_SEARCH = 7'b0000010,
        PH_WS1    = 7'b0000100,
        PH_WS2    = 7'b0001000,
        PH_NAME   = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_FAIL   = 7'b1000000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       match_pos_reg, match_pos_next;
    logic [DOC_W-1:0] doc_count_reg, doc_count_next;
    logic             quote_single_reg, quote_single_next;
    logic [LEN_W-1:0] name_len_reg, name_len_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic [7:0]       b;
    logic [7:0]       close_quote;
    logic [3:0]       kw_pos;

    assign s_ready     = !q_full;
    assign accept      = s_valid && s_ready;
    assign b           = s_payload.byte_in;
    assign close_quote = quote_single_reg ? CH_SQUOTE : CH_DQUOTE;

    always_comb begin
        phase_next        = phase_reg;
        match_pos_next    = match_pos_reg;
        doc_count_next    = doc_count_reg;
        quote_single_next = quote_single_reg;
        name_len_next     = name_len_reg;
        bank_next         = bank_reg;
        kw_pos            = 4'd0;
        wr                = '0;
        q_push            = 1'b0;
        q_cmd             = '0;
        if (accept) begin
            if (doc_count_reg < MIN_DOC) begin
                doc_count_next = doc_count_reg + 1'b1;
            end
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (match_pos_reg < OPENER_LEN &&
                        b == opener_char(match_pos_reg[2:0])) begin
                        if (match_pos_reg + 1'b1 == OPENER_LEN) begin
                            phase_next     = PH_SEARCH;
                            match_pos_next = 4'd0;
                        end else begin
                            match_pos_next = match_pos_reg + 1'b1;
                        end
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_SEARCH: begin
                    if (b == CH_NUL) begin
                        phase_next = PH_FAIL;
                    end else begin
                        // The keyword has no self-overlap, so a mismatch restarts on this byte.
                        if (b == keyword_char(match_pos_reg[2:0])) begin
                            kw_pos = match_pos_reg + 1'b1;
                        end else if (b == keyword_char(3'd0)) begin
                            kw_pos = 4'd1;
                        end else begin
                            kw_pos = 4'd0;
                        end
                        if (kw_pos == KEYWORD_LEN) begin
                            phase_next     = PH_WS1;
                            match_pos_next = 4'd0;
                        end else begin
                            match_pos_next = kw_pos;
                        end
                    end
                end
                PH_WS1: begin
                    if (b == CH_EQUALS) begin
                        phase_next = PH_WS2;
                    end else if (b != CH_SPACE && b != CH_TAB) begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_WS2: begin
                    if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                        quote_single_next = (b == CH_SQUOTE);
                        name_len_next     = '0;
                        phase_next        = PH_NAME;
                    end else if (b != CH_SPACE && b != CH_TAB) begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_NAME: begin
                    if (b == close_quote) begin
                        phase_next = (name_len_reg != '0) ? PH_DONE : PH_FAIL;
                    end else if (name_len_reg < LEN_W'(NAME_MAX)) begin
                        wr.en         = 1'b1;
                        wr.bank       = bank_reg;
                        wr.addr       = name_len_reg[ADDR_W-1:0];
                        wr.data       = b;
                        name_len_next = name_len_reg + 1'b1;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_DONE, PH_FAIL: begin
                end
                default: phase_next = PH_FAIL;
            endcase
            if (s_payload.end_of_doc) begin
                q_push            = 1'b1;
                q_cmd.bank        = bank_reg;
                q_cmd.found       = (phase_next == PH_DONE) && (doc_count_next >= MIN_DOC);
                q_cmd.len         = name_len_next;
                bank_next         = !bank_reg;
                phase_next        = PH_PREFIX;
                match_pos_next    = 4'd0;
                doc_count_next    = '0;
                quote_single_next = 1'b0;
                name_len_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_PREFIX;
            match_pos_reg    <= 4'd0;
            doc_count_reg    <= '0;
            quote_single_reg <= 1'b0;
            name_len_reg     <= '0;
            bank_reg         <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            match_pos_reg    <= match_pos_next;
            doc_count_reg    <= doc_count_next;
            quote_single_reg <= quote_single_next;
            name_len_reg     <= name_len_next;
            bank_reg         <= bank_next;
        end
    end

endmodule

// ===== src/xed_queue.sv =====
// Two-entry queue of finished-document requests between front and back.
module xed_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  xed_pkg::xed_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output xed_pkg::xed_cmd_t head,
    output logic              empty
);
    import xed_pkg::*;

    xed_cmd_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        priority if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/xed_back.sv =====
// Back end: holds the two-bank name store and plays each request out as results.
module xed_back #(
    parameter int NAME_MAX = xed_pkg::NAME_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  xed_pkg::xed_wr_t  wr,
    input  logic              q_empty,
    input  xed_pkg::xed_cmd_t q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output xed_pkg::xed_out_t m_payload
);
    import xed_pkg::*;

    localparam int AW    = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam int DEPTH = 2 * (2 ** AW);

    logic [7:0]       store_mem [DEPTH];
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             rd_valid_reg;
    logic             rd_found_reg;
    logic             rd_last_reg;
    logic [7:0]       rd_data_reg;
    logic             out_valid_reg;
    xed_out_t         out_reg;
    logic             advance;
    logic             issue;
    logic             item_last;

    // Both stages move together; a new read is issued only when the output can move.
    assign advance   = !out_valid_reg || m_ready;
    assign issue     = advance && !q_empty;
    assign item_last = !q_head.found || (idx_reg == q_head.len - 1'b1);
    assign q_pop     = issue && item_last;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    always_comb begin
        idx_next = idx_reg;
        if (issue) begin
            idx_next = item_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            store_mem[{wr.bank, wr.addr[AW-1:0]}] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (advance) begin
                rd_valid_reg  <= issue;
                out_valid_reg <= rd_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_data_reg       <= store_mem[{q_head.bank, idx_reg[AW-1:0]}];
            rd_found_reg      <= q_head.found;
            rd_last_reg       <= item_last;
            out_reg.name_byte <= rd_found_reg ? rd_data_reg : 8'h00;
            out_reg.found     <= rd_found_reg;
            out_reg.run_last  <= rd_last_reg;
        end
    end

endmodule

// ===== src/xml_encoding_decl_extractor_core.sv =====
// Result path: a finished document's request goes from the request queue through the read stage to the output register.
// Throughput if unstalled: one byte per cycle in; a found name drains at one byte per cycle, else one result.
// The front stalls only while two finished documents wait in the request queue (two store banks).
// Reset: synchronous, active low; clears parser, queue and output state, not the name store.
module xml_encoding_decl_extractor_core #(
    parameter int NAME_MAX = xed_pkg::NAME_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  xed_pkg::xed_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output xed_pkg::xed_out_t m_payload
);
    import xed_pkg::*;

    logic     q_full;
    logic     q_empty;
    logic     q_push;
    logic     q_pop;
    xed_cmd_t q_cmd;
    xed_cmd_t q_head;
    xed_wr_t  wr;

    xed_front #(.NAME_MAX(NAME_MAX)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd),
        .wr        (wr)
    );

    xed_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    xed_back #(.NAME_MAX(NAME_MAX)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== src/xed_checker.sv =====
// Port-level checks for the extractor, bound to the top level.
module xed_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input xed_pkg::xed_in_t  s_payload,
    input logic              m_valid,
    input logic              m_ready,
    input xed_pkg::xed_out_t m_payload
);
    import xed_pkg::*;

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // A not-found request is a single result carrying a zero byte.
    a_not_found_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.found |-> m_payload.run_last && m_payload.name_byte == 8'h00)
        else $error("malformed not-found result");

    // Name bytes of one run follow each other without gaps.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_payload.found && !m_payload.run_last |=>
            m_valid && m_payload.found)
        else $error("gap inside a name run");

    // Nothing is offered straight out of reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind xml_encoding_decl_extractor_core xed_checker u_xed_checker (.*);
